>>> design/svpwm_pkg.sv
// Shared types, constants and functions of the space vector PWM duty generator.
// Holds the request and result structs, the configuration layout and the sine table.
// No dependencies; every other file of the block takes names from here by scope.
package svpwm_pkg;

  // Angle and sine table geometry.
  localparam int SINE_ENTRIES = 1024;
  localparam int ANGLE_BITS   = 16;
  localparam int SINE_IDX_W   = $clog2(SINE_ENTRIES);
  localparam int QUARTER_ENTRIES = SINE_ENTRIES / 4;
  localparam int QTR_IDX_W    = SINE_IDX_W - 2;
  localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  // Fixed point constants of the sine polynomial and the reference axes.
  localparam longint unsigned ONE_Q30     = 64'd1073741824;
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam logic signed [18:0] SQRT3_Q16   = 19'sd113512;
  localparam logic signed [18:0] UNIT_Q16    = 19'sd65536;
  localparam logic signed [49:0] AXIS_SCALE  = 50'sd131072;

  // Datapath widths.
  localparam int T_W            = 22;               // one active time in Q16 counts
  localparam int SUM_W          = T_W + 1;          // sum of both active times
  localparam int SQ_W           = SUM_W;            // quotient bits of proportional scaling
  localparam int SCALE_PERIOD_W = SQ_W - 16;        // period bits that matter when scaling
  localparam int SR_W           = T_W + SCALE_PERIOD_W + 16;
  localparam int TS_W           = 32;               // period in Q16 counts
  localparam int DQ_W           = 16;               // duty quotient bits
  localparam int DR_W           = TS_W + DQ_W + 1;  // duty dividend

  // Decoupling queue.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ZERO_OFFSET = 3'd0,
    CFG_POLE_PAIRS  = 3'd1,
    CFG_REVERSE     = 3'd2,
    CFG_TIME_GAIN   = 3'd3,
    CFG_PERIOD      = 3'd4,
    CFG_MAX_DUTY    = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] zero_offset;
    logic [6:0]  pole_pairs;
    logic        reverse;
    logic [15:0] time_gain;
    logic [15:0] period;
    logic [15:0] max_duty;
  } cfg_t;

  typedef logic signed [15:0] sine_t;
  typedef sine_t qsine_tab_t [QUARTER_ENTRIES];

  typedef struct packed {
    logic [15:0]        mech_angle;
    logic signed [15:0] q_voltage;
    logic signed [15:0] d_voltage;
  } in_item_t;

  typedef struct packed {
    logic [15:0] duty_u;
    logic [15:0] duty_v;
    logic [15:0] duty_w;
    logic [2:0]  sector;
  } out_item_t;

  // Request after the angle stage: sine, cosine and the voltage commands.
  typedef struct packed {
    sine_t              sn;
    sine_t              cs;
    logic signed [15:0] q;
    logic signed [15:0] d;
  } angle_item_t;

  // Phase on-times handed from the vector time stages to the duty stages.
  typedef struct packed {
    logic [TS_W-1:0] ta;
    logic [TS_W-1:0] tb;
    logic [TS_W-1:0] tc;
    logic [2:0]      sector;
  } phase_t;

  // One sine table entry from the odd ninth order polynomial, Q1.15.
  function automatic sine_t sine_entry(input int unsigned k);
    longint unsigned kk, a, quad, r, t, t2, p, s, v;
    kk = 64'(k);
    a = ((kk % 64'(SINE_ENTRIES)) << 32) / 64'(SINE_ENTRIES);
    quad = (a >> 30) & 64'd3;
    r = a & (ONE_Q30 - 64'd1);
    if (quad[0]) begin
      r = ONE_Q30 - r;
    end
    t  = (r * PI_HALF_Q30) >> 30;
    t2 = (t * t) >> 30;
    p  = ONE_Q30 - t2 / 64'd72;
    p  = ONE_Q30 - ((t2 * p) >> 30) / 64'd42;
    p  = ONE_Q30 - ((t2 * p) >> 30) / 64'd20;
    p  = ONE_Q30 - ((t2 * p) >> 30) / 64'd6;
    s  = (t * p) >> 30;
    v  = (s * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return (quad >= 64'd2) ? -sine_t'(v[15:0]) : sine_t'(v[15:0]);
  endfunction

  // First quarter of the wave; the other quarters follow by symmetry.
  function automatic qsine_tab_t build_quarter_tab();
    qsine_tab_t tab;
    for (int k = 0; k < QUARTER_ENTRIES; k++) begin
      tab[k] = sine_entry(k);
    end
    return tab;
  endfunction

  localparam qsine_tab_t QSINE_TAB    = build_quarter_tab();
  localparam sine_t      QUARTER_PEAK = sine_entry(QUARTER_ENTRIES);

  // Full-turn sine lookup folded onto the quarter table.
  function automatic sine_t sine_lookup(input logic [SINE_IDX_W-1:0] idx);
    logic [1:0]           quad;
    logic [QTR_IDX_W-1:0] r;
    sine_t                mag;
    quad = idx[SINE_IDX_W-1 -: 2];
    r    = idx[QTR_IDX_W-1:0];
    if (!quad[0]) begin
      mag = QSINE_TAB[r];
    end else if (r == '0) begin
      mag = QUARTER_PEAK;
    end else begin
      mag = QSINE_TAB[QTR_IDX_W'(0) - r];
    end
    return quad[1] ? -mag : mag;
  endfunction

  // Electric angle widened from 16 bits to ANGLE_BITS.
  function automatic logic [ANGLE_BITS-1:0] widen_angle(input logic [15:0] e);
    logic [31:0] wide;
    wide = {e, 16'b0} >> (32 - ANGLE_BITS);
    return wide[ANGLE_BITS-1:0];
  endfunction

  // Sector from the signs of the three reference axes.
  function automatic logic [2:0] sector_of_code(input logic [2:0] code);
    logic [2:0] sec;
    case (code)
      3'd1:    sec = 3'd2;
      3'd2:    sec = 3'd6;
      3'd3:    sec = 3'd1;
      3'd4:    sec = 3'd4;
      3'd5:    sec = 3'd3;
      3'd6:    sec = 3'd5;
      default: sec = 3'd0;
    endcase
    return sec;
  endfunction

endpackage

>>> design/svpwm_front.sv
// Front end: accepts requests, forms the electric angle and looks up sine and cosine.
// Uses svpwm_pkg; pushes finished requests into svpwm_fifo.
module svpwm_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  svpwm_pkg::cfg_t       cfg,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  svpwm_pkg::in_item_t   in_data,
  input  logic                  fifo_full,
  output logic                  push,
  output svpwm_pkg::angle_item_t push_data
);

  logic                              fen;
  logic                              f1_v_r;
  logic [15:0]                       e16_r, e16_nxt;
  logic signed [15:0]                q1_r, d1_r;
  logic                              f2_v_r;
  svpwm_pkg::angle_item_t            f2_r, f2_nxt;
  logic [15:0]                       diff;
  logic [22:0]                       prod;
  logic [svpwm_pkg::ANGLE_BITS-1:0]  ea, ea_cos;

  // The whole front moves unless a finished request cannot enter the queue.
  assign fen      = !(f2_v_r && fifo_full);
  assign in_stall = !fen;
  assign push     = f2_v_r && !fifo_full;
  assign push_data = f2_r;

  // Electric angle: offset, pole pair multiply, optional reversal.
  always_comb begin
    diff = in_data.mech_angle - cfg.zero_offset;
    prod = 23'(diff) * 23'(cfg.pole_pairs);
    e16_nxt = prod[15:0];
    if (cfg.reverse) begin
      e16_nxt = 16'd0 - prod[15:0];
    end
  end

  // Sine and cosine table reads.
  always_comb begin
    ea     = svpwm_pkg::widen_angle(e16_r);
    ea_cos = ea + svpwm_pkg::QUARTER_TURN;
    f2_nxt.sn = svpwm_pkg::sine_lookup(ea[svpwm_pkg::ANGLE_BITS-1 -: svpwm_pkg::SINE_IDX_W]);
    f2_nxt.cs = svpwm_pkg::sine_lookup(
                  ea_cos[svpwm_pkg::ANGLE_BITS-1 -: svpwm_pkg::SINE_IDX_W]);
    f2_nxt.q  = q1_r;
    f2_nxt.d  = d1_r;
  end

  // Stage valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else if (fen) begin
      f1_v_r <= in_valid;
      f2_v_r <= f1_v_r;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (fen) begin
      e16_r <= e16_nxt;
      q1_r  <= in_data.q_voltage;
      d1_r  <= in_data.d_voltage;
      f2_r  <= f2_nxt;
    end
  end

endmodule

>>> design/svpwm_fifo.sv
// Short queue between the front end and the vector time stages.
// Uses svpwm_pkg for the entry type and depth.
module svpwm_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  svpwm_pkg::angle_item_t push_data,
  output logic                   full,
  input  logic                   pop,
  output logic                   pop_valid,
  output svpwm_pkg::angle_item_t pop_data
);

  svpwm_pkg::angle_item_t            mem_r [svpwm_pkg::FIFO_DEPTH];
  logic [svpwm_pkg::FIFO_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [svpwm_pkg::FIFO_CNT_W-1:0]  count_r, count_nxt;

  assign full      = (count_r == svpwm_pkg::FIFO_CNT_W'(svpwm_pkg::FIFO_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  // Occupancy follows pushes and pops.
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // The queue never holds more than its depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= svpwm_pkg::FIFO_CNT_W'(svpwm_pkg::FIFO_DEPTH))
    else $error("queue count beyond depth");

  // No request is taken from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("pop from empty queue");

  // No request is written into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  // A lone push grows the count by one.
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not follow a push");

endmodule

>>> design/svpwm_back.sv
// Vector time stages: inverse Park, sector, active times, proportional scaling and phase on-times.
// Uses svpwm_pkg; takes requests from svpwm_fifo and feeds phase times to svpwm_duty.
module svpwm_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  svpwm_pkg::cfg_t        cfg,
  input  logic                   adv,
  input  logic                   pop_valid,
  input  svpwm_pkg::angle_item_t pop_data,
  output logic                   pop,
  output logic                   ph_valid,
  output svpwm_pkg::phase_t      ph_data
);

  typedef struct packed {
    logic [2:0]                   sector;
    logic [svpwm_pkg::T_W-1:0]    t1;
    logic [svpwm_pkg::T_W-1:0]    t2;
    logic [svpwm_pkg::SUM_W-1:0]  sum;
    logic                         scale;
    logic [svpwm_pkg::SR_W-1:0]   rem1;
    logic [svpwm_pkg::SR_W-1:0]   rem2;
    logic [svpwm_pkg::SQ_W-1:0]   quo1;
    logic [svpwm_pkg::SQ_W-1:0]   quo2;
  } scale_stage_t;

  localparam int PROD_W = svpwm_pkg::T_W + svpwm_pkg::SCALE_PERIOD_W;

  logic                        b1_v_r, b2_v_r, b3_v_r, b5_v_r;
  logic signed [31:0]          alpha_r, alpha_nxt, beta_r, beta_nxt;
  logic signed [49:0]          w2, w3;
  logic [2:0]                  sec2_r, sec2_nxt, sec3_r;
  logic signed [31:0]          v1_r;
  logic signed [33:0]          v2_r, v2_nxt, v3_r, v3_nxt;
  logic signed [34:0]          op1, op2;
  logic [svpwm_pkg::T_W-1:0]   t1_r, t1_nxt, t2_r, t2_nxt;
  logic                        sv_r [svpwm_pkg::SQ_W+1];
  scale_stage_t                sd_r [svpwm_pkg::SQ_W+1];
  scale_stage_t                sd_nxt [svpwm_pkg::SQ_W+1];
  logic [PROD_W-1:0]           p1, p2;
  logic [svpwm_pkg::TS_W-1:0]  ts32;
  svpwm_pkg::phase_t           ph_r, ph_nxt;

  assign pop      = adv && pop_valid;
  assign ph_valid = b5_v_r;
  assign ph_data  = ph_r;
  assign ts32     = {cfg.period, 16'b0};

  // Active time of one reference axis value, zero unless positive.
  function automatic logic [svpwm_pkg::T_W-1:0] axis_time(input logic signed [34:0] v,
                                                        input logic [15:0] k);
    logic [49:0] prod;
    prod = 50'(k) * 50'(v[33:0]);
    return (v > 0) ? prod[26 +: svpwm_pkg::T_W] : '0;
  endfunction

  // Inverse Park transform.
  always_comb begin
    alpha_nxt = pop_data.d * pop_data.cs - pop_data.q * pop_data.sn;
    beta_nxt  = pop_data.d * pop_data.sn + pop_data.q * pop_data.cs;
  end

  // Reference axes, their signs and the axis values truncated toward zero.
  always_comb begin
    w2 = alpha_r * svpwm_pkg::SQRT3_Q16 - beta_r * svpwm_pkg::UNIT_Q16;
    w3 = -(alpha_r * svpwm_pkg::SQRT3_Q16) - beta_r * svpwm_pkg::UNIT_Q16;
    sec2_nxt = svpwm_pkg::sector_of_code({w3 > 0, w2 > 0, beta_r > 0});
    v2_nxt = 34'(w2 / svpwm_pkg::AXIS_SCALE);
    v3_nxt = 34'(w3 / svpwm_pkg::AXIS_SCALE);
  end

  // Choose the two axis values that give the active times of the sector.
  always_comb begin
    op1 = '0;
    op2 = '0;
    case (sec2_r)
      3'd1: begin op2 = 35'(v1_r);  op1 = 35'(v2_r);  end
      3'd2: begin op2 = -35'(v2_r); op1 = -35'(v3_r); end
      3'd3: begin op1 = 35'(v1_r);  op2 = 35'(v3_r);  end
      3'd4: begin op2 = -35'(v1_r); op1 = -35'(v2_r); end
      3'd5: begin op2 = 35'(v2_r);  op1 = 35'(v3_r);  end
      3'd6: begin op1 = -35'(v1_r); op2 = -35'(v3_r); end
      default: begin op1 = '0; op2 = '0; end
    endcase
    t1_nxt = axis_time(op1, cfg.time_gain);
    t2_nxt = axis_time(op2, cfg.time_gain);
  end

  // Proportional scaling: one quotient bit per stage for each active time.
  always_comb begin
    logic [svpwm_pkg::SR_W-1:0] dsh;
    p1 = PROD_W'(t1_r) * PROD_W'(cfg.period[svpwm_pkg::SCALE_PERIOD_W-1:0]);
    p2 = PROD_W'(t2_r) * PROD_W'(cfg.period[svpwm_pkg::SCALE_PERIOD_W-1:0]);
    sd_nxt[0].sector = sec3_r;
    sd_nxt[0].t1     = t1_r;
    sd_nxt[0].t2     = t2_r;
    sd_nxt[0].sum    = svpwm_pkg::SUM_W'(t1_r) + svpwm_pkg::SUM_W'(t2_r);
    sd_nxt[0].scale  = svpwm_pkg::TS_W'(sd_nxt[0].sum) > ts32;
    sd_nxt[0].rem1   = {p1, 16'b0};
    sd_nxt[0].rem2   = {p2, 16'b0};
    sd_nxt[0].quo1   = '0;
    sd_nxt[0].quo2   = '0;
    for (int k = 0; k < svpwm_pkg::SQ_W; k++) begin
      sd_nxt[k+1] = sd_r[k];
      dsh = svpwm_pkg::SR_W'(sd_r[k].sum) << (svpwm_pkg::SQ_W - 1 - k);
      if (sd_r[k].rem1 >= dsh) begin
        sd_nxt[k+1].rem1 = sd_r[k].rem1 - dsh;
        sd_nxt[k+1].quo1[svpwm_pkg::SQ_W-1-k] = 1'b1;
      end
      if (sd_r[k].rem2 >= dsh) begin
        sd_nxt[k+1].rem2 = sd_r[k].rem2 - dsh;
        sd_nxt[k+1].quo2[svpwm_pkg::SQ_W-1-k] = 1'b1;
      end
    end
  end

  // Seven-segment phase on-times from the (possibly scaled) active times.
  always_comb begin
    logic [svpwm_pkg::TS_W-1:0] t1f, t2f, t0, th;
    t1f = sd_r[svpwm_pkg::SQ_W].scale
        ? svpwm_pkg::TS_W'(sd_r[svpwm_pkg::SQ_W].quo1[svpwm_pkg::T_W-1:0])
        : svpwm_pkg::TS_W'(sd_r[svpwm_pkg::SQ_W].t1);
    t2f = sd_r[svpwm_pkg::SQ_W].scale
        ? svpwm_pkg::TS_W'(sd_r[svpwm_pkg::SQ_W].quo2[svpwm_pkg::T_W-1:0])
        : svpwm_pkg::TS_W'(sd_r[svpwm_pkg::SQ_W].t2);
    t0 = sd_r[svpwm_pkg::SQ_W].scale
       ? '0 : ts32 - svpwm_pkg::TS_W'(sd_r[svpwm_pkg::SQ_W].sum);
    th = t0 >> 1;
    ph_nxt.sector = sd_r[svpwm_pkg::SQ_W].sector;
    ph_nxt.ta = ts32 >> 1;
    ph_nxt.tb = ts32 >> 1;
    ph_nxt.tc = ts32 >> 1;
    case (sd_r[svpwm_pkg::SQ_W].sector)
      3'd1: begin ph_nxt.ta = t1f + t2f + th; ph_nxt.tb = t2f + th; ph_nxt.tc = th; end
      3'd2: begin ph_nxt.ta = t1f + th; ph_nxt.tb = t1f + t2f + th; ph_nxt.tc = th; end
      3'd3: begin ph_nxt.ta = th; ph_nxt.tb = t1f + t2f + th; ph_nxt.tc = t2f + th; end
      3'd4: begin ph_nxt.ta = th; ph_nxt.tb = t1f + th; ph_nxt.tc = t1f + t2f + th; end
      3'd5: begin ph_nxt.ta = t2f + th; ph_nxt.tb = th; ph_nxt.tc = t1f + t2f + th; end
      3'd6: begin ph_nxt.ta = t1f + t2f + th; ph_nxt.tb = th; ph_nxt.tc = t1f + th; end
      default: ph_nxt.sector = sd_r[svpwm_pkg::SQ_W].sector;
    endcase
  end

  // Stage valids move together with the output side.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      b3_v_r <= 1'b0;
      b5_v_r <= 1'b0;
      for (int k = 0; k <= svpwm_pkg::SQ_W; k++) begin
        sv_r[k] <= 1'b0;
      end
    end else if (adv) begin
      b1_v_r <= pop;
      b2_v_r <= b1_v_r;
      b3_v_r <= b2_v_r;
      sv_r[0] <= b3_v_r;
      for (int k = 0; k < svpwm_pkg::SQ_W; k++) begin
        sv_r[k+1] <= sv_r[k];
      end
      b5_v_r <= sv_r[svpwm_pkg::SQ_W];
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (adv) begin
      alpha_r <= alpha_nxt;
      beta_r  <= beta_nxt;
      sec2_r  <= sec2_nxt;
      v1_r    <= beta_r;
      v2_r    <= v2_nxt;
      v3_r    <= v3_nxt;
      sec3_r  <= sec2_r;
      t1_r    <= t1_nxt;
      t2_r    <= t2_nxt;
      sd_r    <= sd_nxt;
      ph_r    <= ph_nxt;
    end
  end

endmodule

>>> design/svpwm_duty.sv
// Duty stages: phase on-times scaled by the duty limit and divided by the period, one quotient bit per stage.
// Uses svpwm_pkg; holds the result register of the block.
module svpwm_duty (
  input  logic                  clk,
  input  logic                  rst_n,
  input  svpwm_pkg::cfg_t       cfg,
  input  logic                  adv,
  input  logic                  ph_valid,
  input  svpwm_pkg::phase_t     ph_data,
  output logic                  out_valid,
  output svpwm_pkg::out_item_t  out_data
);

  typedef struct packed {
    logic [2:0]                            sector;
    logic [2:0][svpwm_pkg::DR_W-1:0]       rem;
    logic [2:0][svpwm_pkg::DQ_W-1:0]       quo;
  } duty_stage_t;

  logic                        dv_r [svpwm_pkg::DQ_W+1];
  duty_stage_t                 dd_r [svpwm_pkg::DQ_W+1];
  duty_stage_t                 dd_nxt [svpwm_pkg::DQ_W+1];
  logic [svpwm_pkg::TS_W-1:0]  ts32;
  logic                        out_valid_r;
  svpwm_pkg::out_item_t        out_r, out_nxt;

  assign ts32      = {cfg.period, 16'b0};
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Rounded dividends, then restoring division by the period.
  always_comb begin
    logic [svpwm_pkg::DR_W-1:0] dsh;
    dd_nxt[0].sector = ph_data.sector;
    dd_nxt[0].rem[0] = svpwm_pkg::DR_W'(ph_data.ta) * svpwm_pkg::DR_W'(cfg.max_duty)
                     + svpwm_pkg::DR_W'(ts32 >> 1);
    dd_nxt[0].rem[1] = svpwm_pkg::DR_W'(ph_data.tb) * svpwm_pkg::DR_W'(cfg.max_duty)
                     + svpwm_pkg::DR_W'(ts32 >> 1);
    dd_nxt[0].rem[2] = svpwm_pkg::DR_W'(ph_data.tc) * svpwm_pkg::DR_W'(cfg.max_duty)
                     + svpwm_pkg::DR_W'(ts32 >> 1);
    dd_nxt[0].quo = '0;
    for (int k = 0; k < svpwm_pkg::DQ_W; k++) begin
      dd_nxt[k+1] = dd_r[k];
      dsh = svpwm_pkg::DR_W'(ts32) << (svpwm_pkg::DQ_W - 1 - k);
      for (int p = 0; p < 3; p++) begin
        if (dd_r[k].rem[p] >= dsh) begin
          dd_nxt[k+1].rem[p] = dd_r[k].rem[p] - dsh;
          dd_nxt[k+1].quo[p][svpwm_pkg::DQ_W-1-k] = 1'b1;
        end
      end
    end
  end

  // Result: zero for a zero period, otherwise capped at the duty limit.
  always_comb begin
    logic [2:0][15:0] duty;
    for (int p = 0; p < 3; p++) begin
      duty[p] = dd_r[svpwm_pkg::DQ_W].quo[p];
      if (duty[p] > cfg.max_duty) begin
        duty[p] = cfg.max_duty;
      end
      if (cfg.period == '0) begin
        duty[p] = '0;
      end
    end
    out_nxt.duty_u = duty[0];
    out_nxt.duty_v = duty[1];
    out_nxt.duty_w = duty[2];
    out_nxt.sector = dd_r[svpwm_pkg::DQ_W].sector;
  end

  // Stage valids and the result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= svpwm_pkg::DQ_W; k++) begin
        dv_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (adv) begin
      dv_r[0] <= ph_valid;
      for (int k = 0; k < svpwm_pkg::DQ_W; k++) begin
        dv_r[k+1] <= dv_r[k];
      end
      out_valid_r <= dv_r[svpwm_pkg::DQ_W];
    end
  end

  // Stage payloads and the result register.
  always_ff @(posedge clk) begin
    if (adv) begin
      dd_r  <= dd_nxt;
      out_r <= out_nxt;
    end
  end

endmodule

>>> design/svpwm_duty_generator.sv
// Top level of the seven-segment space vector PWM duty generator.
// Uses svpwm_pkg and instantiates svpwm_front, svpwm_fifo, svpwm_back and svpwm_duty.
//
// Each request carries a shaft angle and the q and d voltage commands; each one
// yields exactly one result with the U/V/W duties and the sector. Requests move
// on in_valid/in_stall and results on out_valid/out_stall; a transfer happens
// at a clock edge where valid is high and stall is low.
// Throughput is one request per clock cycle while neither side stalls. On its
// way a request passes two front stages (angle, loaded at the edge that takes
// the request, and sine table), the queue, three vector stages, the sum stage,
// 23 proportional scaling stages, the phase time stage, the rounding multiply
// and 16 duty division stages, then the result register.
// When the receiver stalls, the result register holds and the back stages
// freeze; the front keeps taking requests until the four-entry queue fills,
// after which in_stall rises.
// The configuration registers are written through cfg_we/cfg_index/cfg_wdata
// and should only change while no request is in flight. Reset (rst_n low,
// synchronous) empties all stages and the queue and loads the default settings.
module svpwm_duty_generator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  svpwm_pkg::in_item_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output svpwm_pkg::out_item_t                out_data,
  input  logic                                cfg_we,
  input  logic [svpwm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [svpwm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  svpwm_pkg::cfg_t        cfg_r;
  logic                   adv;
  logic                   push, full, pop, pop_valid, ph_valid;
  svpwm_pkg::angle_item_t push_data, pop_data;
  svpwm_pkg::phase_t      ph_data;

  // The back stages advance whenever the result register is free or being taken.
  assign adv = !out_valid || !out_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zero_offset <= 16'd0;
      cfg_r.pole_pairs  <= 7'd7;
      cfg_r.reverse     <= 1'b0;
      cfg_r.time_gain   <= 16'd4096;
      cfg_r.period      <= 16'd1000;
      cfg_r.max_duty    <= 16'd62258;
    end else if (cfg_we) begin
      unique case (svpwm_pkg::cfg_idx_t'(cfg_index))
        svpwm_pkg::CFG_ZERO_OFFSET: cfg_r.zero_offset <= cfg_wdata;
        svpwm_pkg::CFG_POLE_PAIRS:  cfg_r.pole_pairs  <= cfg_wdata[6:0];
        svpwm_pkg::CFG_REVERSE:     cfg_r.reverse     <= cfg_wdata[0];
        svpwm_pkg::CFG_TIME_GAIN:   cfg_r.time_gain   <= cfg_wdata;
        svpwm_pkg::CFG_PERIOD:      cfg_r.period      <= cfg_wdata;
        svpwm_pkg::CFG_MAX_DUTY:    cfg_r.max_duty    <= cfg_wdata;
        default:                    cfg_r             <= cfg_r;
      endcase
    end
  end

  svpwm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .fifo_full (full),
    .push      (push),
    .push_data (push_data)
  );

  svpwm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_data  (pop_data)
  );

  svpwm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .adv       (adv),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop       (pop),
    .ph_valid  (ph_valid),
    .ph_data   (ph_data)
  );

  svpwm_duty u_duty (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .adv       (adv),
    .ph_valid  (ph_valid),
    .ph_data   (ph_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
